/* sv/lob_pkg.sv */
// Shared types and constants of the order book matcher.
package lob_pkg;

	localparam int IdW    = 64;
	localparam int AmtW   = 32;
	localparam int PriceW = 32;
	localparam int AgeW   = 32;
	localparam int KindW  = 3;
	localparam int ReqW   = 3;

	localparam int MAX_RESULTS = 32;
	localparam int NW          = $clog2(MAX_RESULTS + 1);

	localparam logic BUY  = 1'b0;
	localparam logic SELL = 1'b1;

	localparam logic [ReqW-1:0] REQ_PLACE = 3'd0;
	localparam logic [ReqW-1:0] REQ_MATCH = 3'd1;
	localparam logic [ReqW-1:0] REQ_MBUY  = 3'd2;
	localparam logic [ReqW-1:0] REQ_MSELL = 3'd3;
	localparam logic [ReqW-1:0] REQ_CLEAR = 3'd4;

	localparam logic [KindW-1:0] K_TRADE  = 3'd0;
	localparam logic [KindW-1:0] K_ACCEPT = 3'd1;
	localparam logic [KindW-1:0] K_FULL   = 3'd2;
	localparam logic [KindW-1:0] K_NONE   = 3'd3;
	localparam logic [KindW-1:0] K_CLEAR  = 3'd4;

	typedef enum logic [2:0] {
		OP_PLACE,
		OP_MATCH,
		OP_MBUY,
		OP_MSELL,
		OP_CLEAR,
		OP_BAD
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [IdW-1:0]    trader;
		logic              side;
		logic [AmtW-1:0]   amount;
		logic [PriceW-1:0] price;
	} req_t;

	typedef struct packed {
		logic [KindW-1:0]  kind;
		logic [IdW-1:0]    seller;
		logic [IdW-1:0]    buyer;
		logic [AmtW-1:0]   amount;
		logic [PriceW-1:0] price;
		logic              last;
	} res_t;

	typedef struct packed {
		logic              valid;
		logic              side;
		logic [IdW-1:0]    trader;
		logic [AmtW-1:0]   amount;
		logic [PriceW-1:0] price;
		logic [AgeW-1:0]   age;
	} slot_t;

	// Queue handshake between front and back.
	typedef struct packed {
		logic valid;
		req_t req;
	} req_beat_t;

endpackage

/* sv/limit_order_book_matcher.sv */
// Top level of the order book matcher: front queue, engine, result queue; one request at a time.
// A place, match or market request starts a scan, which reads one slot a cycle, then ranks and decides.
// A place ends after one scan, once the result queue has room; a match or market runs one scan per
// trade, plus write states WR_A and WR_B per match trade or WR_A alone per market trade, then one
// more scan that ends it (or stops at MAX_RESULTS trades), and a report. A clear wipes every slot, then reports.
// Reset starts a clearing pass over every slot; full stays high until it ends.
module limit_order_book_matcher #(
	parameter int BOOK_DEPTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [lob_pkg::ReqW-1:0]          req_type,
	input  logic [lob_pkg::IdW-1:0]           trader_id,
	input  logic                              side,
	input  logic [lob_pkg::AmtW-1:0]          order_amount,
	input  logic [lob_pkg::PriceW-1:0]        limit_price,
	output logic                              empty,
	input  logic                              pop,
	output logic [lob_pkg::KindW-1:0]         result_kind,
	output logic [lob_pkg::IdW-1:0]           seller_id,
	output logic [lob_pkg::IdW-1:0]           buyer_id,
	output logic [lob_pkg::AmtW-1:0]          trade_amount,
	output logic [lob_pkg::PriceW-1:0]        trade_price,
	output logic                              last_in_run
);

	lob_pkg::req_beat_t head;
	logic               take;
	logic               init;
	logic               res_en;
	lob_pkg::res_t      res;
	logic               room;
	lob_pkg::res_t      out_head;

	lob_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.hold         (init),
		.push         (push),
		.full         (full),
		.req_type     (req_type),
		.trader_id    (trader_id),
		.side         (side),
		.order_amount (order_amount),
		.limit_price  (limit_price),
		.head         (head),
		.take         (take)
	);

	lob_engine #(
		.BOOK_DEPTH (BOOK_DEPTH)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.take   (take),
		.init   (init),
		.res_en (res_en),
		.res    (res),
		.room   (room)
	);

	lob_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_en),
		.wr_data (res),
		.room    (room),
		.empty   (empty),
		.pop     (pop),
		.head    (out_head)
	);

	assign result_kind  = out_head.kind;
	assign seller_id    = out_head.seller;
	assign buyer_id     = out_head.buyer;
	assign trade_amount = out_head.amount;
	assign trade_price  = out_head.price;
	assign last_in_run  = out_head.last;

	// Every result that is not a trade closes its request.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_kind != lob_pkg::K_TRADE |-> last_in_run)
		else $error("non-trade result not marked last");

	// Only trades carry accounts.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_kind != lob_pkg::K_TRADE |-> seller_id == '0 && buyer_id == '0)
		else $error("non-trade result carries accounts");

	// No request is taken while the reset clearing pass runs.
	assert property (@(posedge clk) disable iff (!arst_n)
		init |-> !take)
		else $error("request taken during clearing pass");

endmodule

/* sv/lob_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lob_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read one word a cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* sv/lob_front.sv */
// Request front: accepts request beats, classifies them, queues them for the engine.
module lob_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        hold,
	input  logic                        push,
	output logic                        full,
	input  logic [lob_pkg::ReqW-1:0]    req_type,
	input  logic [lob_pkg::IdW-1:0]     trader_id,
	input  logic                        side,
	input  logic [lob_pkg::AmtW-1:0]    order_amount,
	input  logic [lob_pkg::PriceW-1:0]  limit_price,
	output lob_pkg::req_beat_t          head,
	input  logic                        take
);

	lob_pkg::req_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	lob_pkg::req_t cls;
	logic          do_push;
	logic          do_take;

	// Classify the request code.
	always_comb begin
		cls.trader = trader_id;
		cls.side   = side;
		cls.amount = order_amount;
		cls.price  = limit_price;
		unique case (req_type)
			lob_pkg::REQ_PLACE: cls.op = lob_pkg::OP_PLACE;
			lob_pkg::REQ_MATCH: cls.op = lob_pkg::OP_MATCH;
			lob_pkg::REQ_MBUY:  cls.op = lob_pkg::OP_MBUY;
			lob_pkg::REQ_MSELL: cls.op = lob_pkg::OP_MSELL;
			lob_pkg::REQ_CLEAR: cls.op = lob_pkg::OP_CLEAR;
			default:            cls.op = lob_pkg::OP_BAD;
		endcase
	end

	assign full       = hold || (cnt_q == 2'd2);
	assign do_push    = push && !full;
	assign do_take    = take && (cnt_q != 2'd0);
	assign head.valid = (cnt_q != 2'd0);
	assign head.req   = ent_q[rd_ptr_q];

	// Store classified beats.
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_take};
		end
	end

endmodule

/* sv/lob_outq.sv */
// Two-entry result queue in front of the result port.
module lob_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  lob_pkg::res_t wr_data,
	output logic          room,
	output logic          empty,
	input  logic          pop,
	output lob_pkg::res_t head
);

	lob_pkg::res_t ent_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	logic          do_wr;
	logic          do_rd;

	assign room  = (cnt_q != 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = ent_q[rd_ptr_q];
	assign do_wr = wr_en && room;
	assign do_rd = pop && !empty;

	// Store result beats.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
		end
	end

endmodule

/* sv/lob_engine.sv */
// Matching engine: clears and scans the book memory, places orders, picks best orders, writes trades.
module lob_engine #(
	parameter int BOOK_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lob_pkg::req_beat_t head,
	output logic               take,
	output logic               init,
	output logic               res_en,
	output lob_pkg::res_t      res,
	input  logic               room
);

	localparam int IW = $clog2(BOOK_DEPTH);
	localparam int SW = $bits(lob_pkg::slot_t);
	localparam logic [IW-1:0] LAST_IDX = IW'(BOOK_DEPTH - 1);

	typedef enum logic [3:0] {
		ST_CLR,
		ST_CLR_DONE,
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_DECIDE,
		ST_WR_A,
		ST_WR_B,
		ST_FINISH
	} state_t;

	state_t                    state_q;
	lob_pkg::req_t             req_q;
	logic [lob_pkg::AmtW-1:0]  amt_q;
	logic [lob_pkg::NW-1:0]    n_q;
	logic                      pend_q;
	lob_pkg::res_t             pend_res_q;
	logic [lob_pkg::AgeW-1:0]  arr_q;
	logic [IW-1:0]             idx_q;
	logic                      clr_emit_q;
	logic                      two_wr_q;
	logic [IW-1:0]             wa_addr_q;
	logic [IW-1:0]             wb_addr_q;
	lob_pkg::slot_t            wa_data_q;
	lob_pkg::slot_t            wb_data_q;

	logic                      eval_v_q;
	logic [IW-1:0]             eval_idx_q;
	logic                      bb_found_q;
	logic [IW-1:0]             bb_idx_q;
	lob_pkg::slot_t            bb_q;
	logic                      sb_found_q;
	logic [IW-1:0]             sb_idx_q;
	lob_pkg::slot_t            sb_q;
	logic                      free_found_q;
	logic [IW-1:0]             free_idx_q;

	logic [SW-1:0]             rd_data;
	lob_pkg::slot_t            w;
	logic                      wr_en;
	logic [IW-1:0]             wr_addr;
	lob_pkg::slot_t            wr_data;

	logic [lob_pkg::AgeW-1:0]  el_w;
	logic [lob_pkg::AgeW-1:0]  el_b;
	logic [lob_pkg::AgeW-1:0]  el_s;
	logic                      buy_better;
	logic                      sell_better;

	logic                      can_trade;
	lob_pkg::res_t             trade;
	logic                      two_wr;
	logic [IW-1:0]             wa_addr;
	logic [IW-1:0]             wb_addr;
	lob_pkg::slot_t            wa_data;
	lob_pkg::slot_t            wb_data;
	logic [lob_pkg::AmtW-1:0]  amt_next;
	logic [lob_pkg::AmtW-1:0]  ra;

	lob_ram #(
		.WIDTH (SW),
		.DEPTH (BOOK_DEPTH)
	) u_book (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	assign w    = lob_pkg::slot_t'(rd_data);
	assign init = (state_q == ST_CLR) && !clr_emit_q;
	assign take = (state_q == ST_IDLE) && head.valid;

	// Rank the slot read back against the best so far.
	always_comb begin
		el_w = arr_q - w.age;
		el_b = arr_q - bb_q.age;
		el_s = arr_q - sb_q.age;
		buy_better  = !bb_found_q || ((w.price != bb_q.price) ? (w.price > bb_q.price)
		                                                       : (el_w > el_b));
		sell_better = !sb_found_q || ((w.price != sb_q.price) ? (w.price < sb_q.price)
		                                                       : (el_w > el_s));
	end

	// Track best bid, best ask and lowest free slot during a scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_v_q     <= 1'b0;
			bb_found_q   <= 1'b0;
			sb_found_q   <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			eval_v_q <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN && idx_q == '0) begin
				bb_found_q   <= 1'b0;
				sb_found_q   <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (eval_v_q) begin
				if (w.valid) begin
					if (w.side == lob_pkg::BUY && buy_better) begin
						bb_found_q <= 1'b1;
					end
					if (w.side == lob_pkg::SELL && sell_better) begin
						sb_found_q <= 1'b1;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		eval_idx_q <= idx_q;
		if (eval_v_q) begin
			if (w.valid && w.side == lob_pkg::BUY && buy_better) begin
				bb_q     <= w;
				bb_idx_q <= eval_idx_q;
			end
			if (w.valid && w.side == lob_pkg::SELL && sell_better) begin
				sb_q     <= w;
				sb_idx_q <= eval_idx_q;
			end
			if (!w.valid && !free_found_q) begin
				free_idx_q <= eval_idx_q;
			end
		end
	end

	// Work out the next trade and the slot updates it needs.
	always_comb begin
		can_trade    = 1'b0;
		trade        = '0;
		trade.kind   = lob_pkg::K_TRADE;
		two_wr       = 1'b0;
		wa_addr      = bb_idx_q;
		wb_addr      = sb_idx_q;
		wa_data      = bb_q;
		wb_data      = sb_q;
		amt_next     = amt_q;
		ra           = '0;
		unique case (req_q.op)
			lob_pkg::OP_MATCH: begin
				can_trade    = bb_found_q && sb_found_q && (bb_q.price >= sb_q.price);
				two_wr       = 1'b1;
				trade.seller = sb_q.trader;
				trade.buyer  = bb_q.trader;
				trade.price  = sb_q.price;
				trade.amount = (bb_q.amount < sb_q.amount) ? bb_q.amount : sb_q.amount;
				priority if (bb_q.amount == sb_q.amount) begin
					wa_data.valid = 1'b0;
					wb_data.valid = 1'b0;
				end else if (bb_q.amount < sb_q.amount) begin
					wa_addr        = sb_idx_q;
					wa_data        = sb_q;
					wa_data.amount = sb_q.amount - bb_q.amount;
					wb_addr        = bb_idx_q;
					wb_data        = bb_q;
					wb_data.valid  = 1'b0;
				end else begin
					wa_data.amount = bb_q.amount - sb_q.amount;
					wb_data.valid  = 1'b0;
				end
			end
			lob_pkg::OP_MBUY, lob_pkg::OP_MSELL: begin
				if (req_q.op == lob_pkg::OP_MBUY) begin
					can_trade    = (amt_q != '0) && sb_found_q;
					wa_addr      = sb_idx_q;
					wa_data      = sb_q;
					trade.seller = sb_q.trader;
					trade.buyer  = req_q.trader;
				end else begin
					can_trade    = (amt_q != '0) && bb_found_q;
					trade.seller = req_q.trader;
					trade.buyer  = bb_q.trader;
				end
				ra           = wa_data.amount;
				trade.price  = wa_data.price;
				trade.amount = (amt_q < ra) ? amt_q : ra;
				if (amt_q >= ra) begin
					amt_next      = amt_q - ra;
					wa_data.valid = 1'b0;
				end else begin
					wa_data.amount = ra - amt_q;
					amt_next       = '0;
				end
			end
			default: begin
				can_trade = 1'b0;
			end
		endcase
	end

	// Drive the memory write port and the result beat.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = '0;
		res_en  = 1'b0;
		res     = '0;
		unique case (state_q)
			ST_CLR: begin
				wr_en = 1'b1;
			end
			ST_CLR_DONE: begin
				res_en   = 1'b1;
				res.kind = lob_pkg::K_CLEAR;
				res.last = 1'b1;
			end
			ST_DECIDE: begin
				if (req_q.op == lob_pkg::OP_PLACE) begin
					res_en   = 1'b1;
					res.last = 1'b1;
					if (free_found_q) begin
						res.kind = lob_pkg::K_ACCEPT;
						wr_en    = room;
						wr_addr  = free_idx_q;
						wr_data  = '{valid: 1'b1, side: req_q.side, trader: req_q.trader,
						             amount: req_q.amount, price: req_q.price, age: arr_q};
					end else begin
						res.kind = lob_pkg::K_FULL;
					end
				end else if (can_trade && pend_q) begin
					res_en = 1'b1;
					res    = pend_res_q;
				end
			end
			ST_WR_A: begin
				wr_en   = 1'b1;
				wr_addr = wa_addr_q;
				wr_data = wa_data_q;
			end
			ST_WR_B: begin
				wr_en   = 1'b1;
				wr_addr = wb_addr_q;
				wr_data = wb_data_q;
			end
			ST_FINISH: begin
				res_en = 1'b1;
				if (pend_q) begin
					res = pend_res_q;
				end else begin
					res.kind = lob_pkg::K_NONE;
				end
				res.last = 1'b1;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Sequence requests: scan, decide, write back, report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			idx_q      <= '0;
			clr_emit_q <= 1'b0;
			arr_q      <= '0;
			pend_q     <= 1'b0;
			n_q        <= '0;
		end else begin
			unique case (state_q)
				ST_CLR: begin
					if (idx_q == LAST_IDX) begin
						idx_q   <= '0;
						arr_q   <= '0;
						state_q <= clr_emit_q ? ST_CLR_DONE : ST_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_CLR_DONE: begin
					if (room) begin
						clr_emit_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (head.valid) begin
						n_q    <= '0;
						pend_q <= 1'b0;
						idx_q  <= '0;
						unique case (head.req.op)
							lob_pkg::OP_CLEAR: begin
								clr_emit_q <= 1'b1;
								state_q    <= ST_CLR;
							end
							lob_pkg::OP_BAD: state_q <= ST_FINISH;
							default:         state_q <= ST_SCAN;
						endcase
					end
				end
				ST_SCAN: begin
					if (idx_q == LAST_IDX) begin
						state_q <= ST_SCAN_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SCAN_LAST: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (req_q.op == lob_pkg::OP_PLACE) begin
						if (room) begin
							if (free_found_q) begin
								arr_q <= arr_q + 1'b1;
							end
							state_q <= ST_IDLE;
						end
					end else if (!can_trade) begin
						state_q <= ST_FINISH;
					end else if (!pend_q || room) begin
						pend_q  <= 1'b1;
						n_q     <= n_q + 1'b1;
						state_q <= ST_WR_A;
					end
				end
				ST_WR_A: begin
					idx_q <= '0;
					if (two_wr_q) begin
						state_q <= ST_WR_B;
					end else begin
						state_q <= (n_q == lob_pkg::NW'(lob_pkg::MAX_RESULTS)) ? ST_FINISH
						                                                         : ST_SCAN;
					end
				end
				ST_WR_B: begin
					state_q <= (n_q == lob_pkg::NW'(lob_pkg::MAX_RESULTS)) ? ST_FINISH : ST_SCAN;
				end
				ST_FINISH: begin
					if (room) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold request payload, market remainder and the pending trade.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && head.valid) begin
			req_q <= head.req;
			amt_q <= head.req.amount;
		end
		if (state_q == ST_DECIDE && req_q.op != lob_pkg::OP_PLACE && can_trade
		    && (!pend_q || room)) begin
			pend_res_q <= trade;
			amt_q      <= amt_next;
			two_wr_q   <= two_wr;
			wa_addr_q  <= wa_addr;
			wb_addr_q  <= wb_addr;
			wa_data_q  <= wa_data;
			wb_data_q  <= wb_data;
		end
	end

endmodule
